// ===== rtl/sle_pkg.sv =====
// Shared types and constants for the scan-line edge locator.
package sle_pkg;

	localparam int PIXEL_W  = 8;
	localparam int SLOPE_W  = 9;
	localparam int WIDTH_W  = 11;
	localparam int COLUMN_W = 10;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam logic [COLUMN_W-1:0] COLUMN_LIMIT = 10'd1023;
	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;

	// Register index decoded from paddr[2]
	localparam logic REG_IMAGE_WIDTH = 1'b0;

	typedef logic signed [SLOPE_W-1:0] slope_t;

	typedef enum logic [1:0] {
		EDGE_BOTH  = 2'd0,
		EDGE_RIGHT = 2'd1,
		EDGE_LEFT  = 2'd2
	} edge_case_t;

endpackage

// ===== rtl/scanline_line_edge_locator_unit.sv =====
// Scan-line edge locator: slope extremes per row and line column at row end.
//
// Usage: pixels of one row enter on the pixel channel (pixel, row_end with
// pixel_valid / pixel_stall), one per transfer, row_end high on the last
// pixel. Each row end yields one transfer on the result channel
// (line_column, edge_case with result_valid / result_stall); other pixels
// yield nothing. The extremes of the first row after reset become the
// reference for the weak-edge tests of every later row.
// Throughput: one pixel per cycle while pixel_stall is low. The forward
// difference and both extreme trackers are updated from the input
// register, which is the loop that sets this rate.
// A row_end pixel reaches the result channel through the input register,
// the row snapshot and the result register.
// The receiver may stall freely: pixels keep flowing while a result waits,
// and pixel_stall rises only when a second row end would overrun the
// snapshot stage behind a held result.
// Reset clears all tracking state, the reference and image_width (640).
// The APB port holds image_width at address 0; pready is always high.
module scanline_line_edge_locator_unit
	import sle_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	// pixel channel
	input  logic                pixel_valid,
	output logic                pixel_stall,
	input  logic [PIXEL_W-1:0]  pixel,
	input  logic                row_end,
	// result channel
	output logic                result_valid,
	input  logic                result_stall,
	output logic [COLUMN_W-1:0] line_column,
	output logic [1:0]          edge_case,
	// configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready
);

	localparam int POS_W = $clog2(MAX_WIDTH);
	localparam int SUM_W = ((POS_W > WIDTH_W) ? POS_W : WIDTH_W) + 1;
	localparam logic [POS_W-1:0] COL_MAX = POS_W'(MAX_WIDTH - 1);

	typedef struct packed {
		slope_t           lo;
		logic [POS_W-1:0] lo_pos;
		slope_t           hi;
		logic [POS_W-1:0] hi_pos;
	} ext_t;

	// One slot into the extremes; earliest position wins a tie
	function automatic ext_t take_slot(ext_t cur, slope_t d, logic [POS_W-1:0] pos);
		ext_t nxt;
		nxt = cur;
		if (pos == '0) begin
			nxt.lo     = d;
			nxt.hi     = d;
			nxt.lo_pos = '0;
			nxt.hi_pos = '0;
		end else begin
			if (d < cur.lo) begin
				nxt.lo     = d;
				nxt.lo_pos = pos;
			end
			if (d > cur.hi) begin
				nxt.hi     = d;
				nxt.hi_pos = pos;
			end
		end
		return nxt;
	endfunction

	// configuration register
	logic [WIDTH_W-1:0] image_width_q;
	logic               cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= WIDTH_RESET;
		end else if (cfg_write && paddr[2] == REG_IMAGE_WIDTH) begin
			image_width_q <= pwdata[WIDTH_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_IMAGE_WIDTH) begin
			prdata = PDATA_W'(image_width_q);
		end
	end

	// flow control through the three stages
	logic valid_s1, valid_s2, result_valid_q;
	logic row_end_s1;
	logic out_free, s2_free, s1_fire, s1_free, s2_fire, pixel_take;

	assign out_free    = !result_valid_q || !result_stall;
	assign s2_free     = !valid_s2 || out_free;
	assign s2_fire     = valid_s2 && out_free;
	assign s1_fire     = valid_s1 && (!row_end_s1 || s2_free);
	assign s1_free     = !valid_s1 || s1_fire;
	assign pixel_stall = !s1_free;
	assign pixel_take  = pixel_valid && s1_free;

	// input register
	logic [PIXEL_W-1:0] pixel_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pixel_take) begin
			pixel_s1   <= pixel;
			row_end_s1 <= row_end;
		end
	end

	// slope tracking state
	logic [PIXEL_W-1:0] prev_q;
	logic [POS_W-1:0]   col_q;
	ext_t               ext_q;
	slope_t             ref_lo_q, ref_hi_q;
	logic               ref_taken_q;

	slope_t d_s1;
	ext_t   ext_mid, ext_end;

	always_comb begin
		d_s1    = slope_t'({1'b0, pixel_s1}) - slope_t'({1'b0, prev_q});
		ext_mid = ext_q;
		if (col_q != '0) begin
			ext_mid = take_slot(ext_q, d_s1, col_q - POS_W'(1));
		end
		ext_end = take_slot(ext_mid, '0, col_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			col_q       <= '0;
			ext_q       <= '0;
			ref_lo_q    <= '0;
			ref_hi_q    <= '0;
			ref_taken_q <= 1'b0;
		end else if (s1_fire) begin
			prev_q <= pixel_s1;
			if (row_end_s1) begin
				col_q <= '0;
				ext_q <= ext_end;
				if (!ref_taken_q) begin
					ref_lo_q    <= ext_end.lo;
					ref_hi_q    <= ext_end.hi;
					ref_taken_q <= 1'b1;
				end
			end else begin
				ext_q <= ext_mid;
				if (col_q < COL_MAX) begin
					col_q <= col_q + POS_W'(1);
				end
			end
		end
	end

	// row snapshot
	ext_t   ext_s2;
	slope_t ref_lo_s2, ref_hi_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_fire && row_end_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && row_end_s1) begin
			ext_s2    <= ext_end;
			ref_lo_s2 <= ref_taken_q ? ref_lo_q : ext_end.lo;
			ref_hi_s2 <= ref_taken_q ? ref_hi_q : ext_end.hi;
		end
	end

	// line column and edge case
	logic signed [SLOPE_W:0] lo_x2, hi_x2, ref_lo_x, ref_hi_x;
	logic                    weak_fall, weak_rise;
	logic [SUM_W-1:0]        sum, half;
	logic [COLUMN_W-1:0]     column;
	edge_case_t              edge_sel;

	always_comb begin
		lo_x2     = {ext_s2.lo, 1'b0};
		hi_x2     = {ext_s2.hi, 1'b0};
		ref_lo_x  = {ref_lo_s2[SLOPE_W-1], ref_lo_s2};
		ref_hi_x  = {ref_hi_s2[SLOPE_W-1], ref_hi_s2};
		weak_fall = lo_x2 > ref_lo_x;
		weak_rise = hi_x2 < ref_hi_x;
		if (weak_fall) begin
			sum      = SUM_W'(ext_s2.hi_pos) + SUM_W'(image_width_q);
			edge_sel = EDGE_RIGHT;
		end else if (weak_rise) begin
			sum      = SUM_W'(ext_s2.lo_pos);
			edge_sel = EDGE_LEFT;
		end else begin
			sum      = SUM_W'(ext_s2.lo_pos) + SUM_W'(ext_s2.hi_pos);
			edge_sel = EDGE_BOTH;
		end
		half   = sum >> 1;
		column = (half > SUM_W'(COLUMN_LIMIT)) ? COLUMN_LIMIT : half[COLUMN_W-1:0];
	end

	// result register
	logic [COLUMN_W-1:0] line_column_q;
	edge_case_t          edge_case_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= s2_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_fire) begin
			line_column_q <= column;
			edge_case_q   <= edge_sel;
		end
	end

	assign result_valid = result_valid_q;
	assign line_column  = line_column_q;
	assign edge_case    = edge_case_q;

endmodule
